// ===== src/biased_soft_knee_clipper_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the biased soft-knee clipper
// Both macros expect a signal named clk in the enclosing module; BSKC_CHECK also needs rst.
// ----------------------------------------------------------------------------
`ifndef BIASED_SOFT_KNEE_CLIPPER_CORE_MACROS_SVH
`define BIASED_SOFT_KNEE_CLIPPER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define BSKC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define BSKC_CHECK_RESET(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bskc_pkg.sv =====
// ----------------------------------------------------------------------------
// bskc_pkg
// Widths, register codes, shared types and arithmetic helpers of the clipper.
// ----------------------------------------------------------------------------
package bskc_pkg;

  // Register port
  localparam int IDXW = 3;
  localparam int CFGW = 23;
  localparam int IGW  = 22;
  localparam int OGW  = 20;
  localparam int BOW  = 23;
  localparam int LMW  = 23;
  localparam int KNW  = 21;

  // Datapath: signed Q.24 working word, knee amount and divider widths
  localparam int XW  = 34;
  localparam int KW  = 25;
  localparam int QW  = 25;
  localparam int DW  = 34;
  localparam int SQW = 2 * KW;

  localparam logic [KNW-1:0] KNEE_MIN  = 21'd105;
  localparam logic [KNW-1:0] KNEE_MAX  = 21'd1048576;
  localparam logic [LMW-1:0] LIMIT_MIN = 23'd1049;

  typedef enum logic [IDXW-1:0] {
    REG_INPUT_GAIN  = 3'd0,
    REG_OUTPUT_GAIN = 3'd1,
    REG_BIAS_OFFSET = 3'd2,
    REG_UPPER_LIMIT = 3'd3,
    REG_LOWER_LIMIT = 3'd4,
    REG_KNEE_WIDTH  = 3'd5
  } reg_index_t;

  // Configuration as the datapath uses it: limits and bias already in Q.24
  typedef struct packed {
    logic        [IGW-1:0] input_gain;
    logic        [OGW-1:0] output_gain;
    logic signed [XW-1:0]  bias;
    logic signed [XW-1:0]  upper;
    logic signed [XW-1:0]  lower;   // negative threshold, sign included
    logic        [KW-1:0]  knee;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    input_gain:  IGW'(65536),
    output_gain: OGW'(65536),
    bias:        '0,
    upper:       XW'(16777216),
    lower:       XW'(-16777216),
    knee:        KW'(1677728)
  };

  // One lane of the restoring divider: remainder, divisor, dividend bits
  // still to shift in, and quotient bits so far
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
  } div_lane_t;

  // Per-item data that rides along the divider chain
  typedef struct packed {
    logic signed [XW-1:0] base_s;
    logic                 neg_s;
    logic signed [XW-1:0] base_b;
    logic                 neg_b;
    logic        [KW-1:0] knee;
  } side_t;

  // Knee region of one value: excess over the threshold and where it starts
  typedef struct packed {
    logic        [DW-1:0] excess;
    logic signed [XW-1:0] base;
    logic                 neg;
  } knee_sel_t;

  function automatic logic signed [XW-1:0] limit_q24(input logic [LMW-1:0] raw);
    logic [LMW-1:0] c;
    c = (raw < LIMIT_MIN) ? LIMIT_MIN : raw;
    return signed'({{(XW-LMW-4){1'b0}}, c, 4'b0000});
  endfunction

  function automatic logic [KW-1:0] knee_q24(input logic [KNW-1:0] raw);
    logic [KNW-1:0] c;
    c = raw;
    if (raw < KNEE_MIN) c = KNEE_MIN;
    if (raw > KNEE_MAX) c = KNEE_MAX;
    return {c, 4'b0000};
  endfunction

  function automatic logic signed [XW-1:0] bias_q24(input logic [BOW-1:0] raw);
    return signed'({{(XW-BOW-4){raw[BOW-1]}}, raw, 4'b0000});
  endfunction

  // Between both thresholds the excess is zero, so the knee term comes out zero
  function automatic knee_sel_t knee_select(input logic signed [XW-1:0] x,
                                            input logic signed [XW-1:0] upper,
                                            input logic signed [XW-1:0] lower);
    knee_sel_t            r;
    logic signed [XW-1:0] d;
    if (x > upper) begin
      d      = x - upper;
      r.base = upper;
      r.neg  = 1'b0;
    end else if (x < lower) begin
      d      = lower - x;
      r.base = lower;
      r.neg  = 1'b1;
    end else begin
      d      = '0;
      r.base = x;
      r.neg  = 1'b0;
    end
    r.excess = d[DW-1:0];
    return r;
  endfunction

  // One restoring division step: shift in a dividend bit, subtract if it fits
  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t   r;
    logic [DW:0] t;
    logic [DW:0] diff;
    t     = {l.rem, l.low[QW-1]};
    diff  = t - {1'b0, l.den};
    r     = l;
    r.low = {l.low[QW-2:0], 1'b0};
    if (!diff[DW]) begin
      r.rem = diff[DW-1:0];
      r.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      r.rem = t[DW-1:0];
      r.quo = {l.quo[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  // e*k/(e+k) = k - ceil(k*k/(e+k)); add or subtract it at the threshold
  function automatic logic signed [XW-1:0] knee_apply(input div_lane_t l,
                                                      input logic signed [XW-1:0] base,
                                                      input logic neg,
                                                      input logic [KW-1:0] k);
    logic [KW:0]          ceil_q;
    logic [KW:0]          term;
    logic signed [XW-1:0] tx;
    ceil_q = {1'b0, l.quo} + {{KW{1'b0}}, |l.rem};
    term   = {1'b0, k} - ceil_q;
    tx     = signed'({{(XW-KW-1){1'b0}}, term});
    return neg ? base - tx : base + tx;
  endfunction

endpackage

// ===== src/bskc_in_if.sv =====
// ----------------------------------------------------------------------------
// bskc_in_if
// Sample channel: valid/ready handshake carrying one input sample.
// ----------------------------------------------------------------------------
interface bskc_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== src/bskc_out_if.sv =====
// ----------------------------------------------------------------------------
// bskc_out_if
// Result channel: valid/ready handshake carrying one shaped sample and flag.
// ----------------------------------------------------------------------------
interface bskc_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

// ===== src/biased_soft_knee_clipper_core.sv =====
// ----------------------------------------------------------------------------
// biased_soft_knee_clipper_core
// Pipeline: 4 front stages, 25 divider cells and 4 back stages from input
// transfer to result valid, one quotient bit per cell.
// Throughput: one sample per cycle; the whole pipeline holds only while a
// result waits at the output register and is not taken.
// Reset: synchronous; empties the pipeline and restores register defaults.
// ----------------------------------------------------------------------------
`include "biased_soft_knee_clipper_core_macros.svh"

module biased_soft_knee_clipper_core #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  bskc_in_if.sink                    sample_chan,
  bskc_out_if.source                 result_chan,
  input  logic                       wr_en,
  input  logic [bskc_pkg::IDXW-1:0]  wr_index,
  input  logic [bskc_pkg::CFGW-1:0]  wr_data
);
  import bskc_pkg::*;

  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  cfg_t      cfg;
  logic      en;
  logic      valid [0:QW];
  div_lane_t lane_s [0:QW];
  div_lane_t lane_b [0:QW];
  side_t     side [0:QW];

  // Hold everything while the output register is full and not taken
  assign en                = !result_chan.valid || result_chan.ready;
  assign sample_chan.ready = en;

  bskc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  bskc_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (sample_chan.valid),
    .sample   (sample_chan.sample_in),
    .cfg      (cfg),
    .valid    (valid[0]),
    .lane_s   (lane_s[0]),
    .lane_b   (lane_b[0]),
    .side     (side[0])
  );

  // Divider chain, one quotient bit per cell
  generate
    for (genvar i = 0; i < QW; i++) begin : g_cell
      bskc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .valid_in  (valid[i]),
        .lane_s_in (lane_s[i]),
        .lane_b_in (lane_b[i]),
        .side_in   (side[i]),
        .valid     (valid[i+1]),
        .lane_s    (lane_s[i+1]),
        .lane_b    (lane_b[i+1]),
        .side      (side[i+1])
      );
    end
  endgenerate

  bskc_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid_in   (valid[QW]),
    .lane_s     (lane_s[QW]),
    .lane_b     (lane_b[QW]),
    .side       (side[QW]),
    .cfg        (cfg),
    .valid      (result_chan.valid),
    .sample_out (result_chan.sample_out),
    .saturated  (result_chan.saturated)
  );

  // Checks
  `BSKC_CHECK(a_sat_at_rail, result_chan.valid && result_chan.saturated |-> result_chan.sample_out == OUT_MAX || result_chan.sample_out == OUT_MIN, "saturated result not at a rail")
  `BSKC_CHECK(a_rem_s_bound, valid[QW] |-> lane_s[QW].rem < lane_s[QW].den, "sample lane remainder not below divisor")
  `BSKC_CHECK(a_rem_b_bound, valid[QW] |-> lane_b[QW].rem < lane_b[QW].den, "bias lane remainder not below divisor")
  `BSKC_CHECK(a_quo_bound, valid[QW] |-> lane_s[QW].quo <= side[QW].knee, "sample lane quotient above knee amount")
  `BSKC_CHECK_RESET(a_reset_empty, rst |=> !result_chan.valid, "result valid right after reset")

endmodule

// ===== src/bskc_regs.sv =====
// ----------------------------------------------------------------------------
// bskc_regs
// Configuration registers; clamps limits and knee and moves them to Q.24.
// ----------------------------------------------------------------------------
module bskc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [bskc_pkg::IDXW-1:0]   wr_index,
  input  logic [bskc_pkg::CFGW-1:0]   wr_data,
  output bskc_pkg::cfg_t              cfg
);
  import bskc_pkg::*;

  // Decode the index and store the converted value; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_INPUT_GAIN:  cfg.input_gain  <= wr_data[IGW-1:0];
        REG_OUTPUT_GAIN: cfg.output_gain <= wr_data[OGW-1:0];
        REG_BIAS_OFFSET: cfg.bias        <= bias_q24(wr_data[BOW-1:0]);
        REG_UPPER_LIMIT: cfg.upper       <= limit_q24(wr_data[LMW-1:0]);
        REG_LOWER_LIMIT: cfg.lower       <= -limit_q24(wr_data[LMW-1:0]);
        REG_KNEE_WIDTH:  cfg.knee        <= knee_q24(wr_data[KNW-1:0]);
        default: ;
      endcase
    end
  end

endmodule

// ===== src/bskc_front.sv =====
// ----------------------------------------------------------------------------
// bskc_front
// Input gain, bias, knee region select and divider operand setup (4 stages).
// ----------------------------------------------------------------------------
module bskc_front #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           valid_in,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  bskc_pkg::cfg_t                 cfg,
  output logic                           valid,
  output bskc_pkg::div_lane_t            lane_s,
  output bskc_pkg::div_lane_t            lane_b,
  output bskc_pkg::side_t                side
);
  import bskc_pkg::*;

  localparam int PW  = SAMPLE_WIDTH + IGW + 1;
  localparam int SH1 = SAMPLE_WIDTH - 9;
  localparam int LW  = (PW + 1 > XW + 1) ? PW + 1 : XW + 1;

  logic                 v1, v2, v3;
  logic signed [PW-1:0] prod1;
  logic [SQW-1:0]       ksq1, ksq2, ksq3;
  logic [KW-1:0]        k1, k2, k3;
  logic signed [LW-1:0] prod_ext;
  logic signed [LW-1:0] vq_wide;
  logic signed [XW-1:0] vq;
  logic signed [XW-1:0] xs2;
  knee_sel_t            sel_s, sel_b, sel_s3, sel_b3;

  // Bring the gain product to Q.24, rounding half up
  assign prod_ext = LW'(prod1);

  generate
    if (SH1 > 0) begin : g_round
      localparam logic signed [LW-1:0] RND1 = {{(LW-1){1'b0}}, 1'b1} << (SH1 - 1);
      assign vq_wide = (prod_ext + RND1) >>> SH1;
    end else if (SH1 == 0) begin : g_exact
      assign vq_wide = prod_ext;
    end else begin : g_up
      assign vq_wide = prod_ext <<< (-SH1);
    end
  endgenerate

  assign vq = vq_wide[XW-1:0];

  // Pick the knee region for the sample and for the bias alone
  always_comb begin
    sel_s = knee_select(xs2, cfg.upper, cfg.lower);
    sel_b = knee_select(cfg.bias, cfg.upper, cfg.lower);
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= valid_in;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  // Advance the payload: gain and k*k, bias add, region, divider setup
  always_ff @(posedge clk) begin
    if (en) begin
      prod1  <= sample * signed'({1'b0, cfg.input_gain});
      ksq1   <= SQW'(cfg.knee * cfg.knee);
      k1     <= cfg.knee;

      xs2    <= vq + cfg.bias;
      ksq2   <= ksq1;
      k2     <= k1;

      sel_s3 <= sel_s;
      sel_b3 <= sel_b;
      ksq3   <= ksq2;
      k3     <= k2;

      lane_s.rem  <= DW'(ksq3[SQW-1:QW]);
      lane_s.den  <= sel_s3.excess + DW'(k3);
      lane_s.low  <= ksq3[QW-1:0];
      lane_s.quo  <= '0;
      lane_b.rem  <= DW'(ksq3[SQW-1:QW]);
      lane_b.den  <= sel_b3.excess + DW'(k3);
      lane_b.low  <= ksq3[QW-1:0];
      lane_b.quo  <= '0;
      side.base_s <= sel_s3.base;
      side.neg_s  <= sel_s3.neg;
      side.base_b <= sel_b3.base;
      side.neg_b  <= sel_b3.neg;
      side.knee   <= k3;
    end
  end

endmodule

// ===== src/bskc_cell.sv =====
// ----------------------------------------------------------------------------
// bskc_cell
// One divider cell: a quotient bit for the sample lane and the bias lane.
// ----------------------------------------------------------------------------
module bskc_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  bskc_pkg::div_lane_t lane_s_in,
  input  bskc_pkg::div_lane_t lane_b_in,
  input  bskc_pkg::side_t     side_in,
  output logic                valid,
  output bskc_pkg::div_lane_t lane_s,
  output bskc_pkg::div_lane_t lane_b,
  output bskc_pkg::side_t     side
);
  import bskc_pkg::*;

  // Hand the valid bit to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  // Do one division step per lane and pass the side data on
  always_ff @(posedge clk) begin
    if (en) begin
      lane_s <= div_step(lane_s_in);
      lane_b <= div_step(lane_b_in);
      side   <= side_in;
    end
  end

endmodule

// ===== src/bskc_back.sv =====
// ----------------------------------------------------------------------------
// bskc_back
// Knee apply, recentre, output gain, rounding and saturation (4 stages).
// ----------------------------------------------------------------------------
module bskc_back #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           valid_in,
  input  bskc_pkg::div_lane_t            lane_s,
  input  bskc_pkg::div_lane_t            lane_b,
  input  bskc_pkg::side_t                side,
  input  bskc_pkg::cfg_t                 cfg,
  output logic                           valid,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           saturated
);
  import bskc_pkg::*;

  localparam int MW  = XW + OGW + 2;
  localparam int SH2 = 24 + 16 - (SAMPLE_WIDTH - 1);
  localparam logic signed [MW-1:0] RND2 = {{(MW-1){1'b0}}, 1'b1} << (SH2 - 1);
  localparam logic signed [MW-1:0] YMAX =
    {{(MW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [MW-1:0] YMIN =
    {{(MW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                 v1, v2, v3;
  logic signed [XW-1:0] lim_s, lim_b;
  logic signed [XW:0]   diff2;
  logic signed [MW-1:0] mul3;
  logic signed [MW-1:0] y;

  assign y = (mul3 + RND2) >>> SH2;

  // Advance the valid bits; the last one flags the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= valid_in;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  // Advance the payload: limit both lanes, subtract, scale, round and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      lim_s <= knee_apply(lane_s, side.base_s, side.neg_s, side.knee);
      lim_b <= knee_apply(lane_b, side.base_b, side.neg_b, side.knee);
      diff2 <= (XW+1)'(lim_s) - (XW+1)'(lim_b);
      mul3  <= diff2 * signed'({1'b0, cfg.output_gain});
      if (y > YMAX) begin
        sample_out <= YMAX[SAMPLE_WIDTH-1:0];
        saturated  <= 1'b1;
      end else if (y < YMIN) begin
        sample_out <= YMIN[SAMPLE_WIDTH-1:0];
        saturated  <= 1'b1;
      end else begin
        sample_out <= y[SAMPLE_WIDTH-1:0];
        saturated  <= 1'b0;
      end
    end
  end

endmodule
